// ===== rtl/core/ple_pkg.sv =====
// ---------------------------------------------------------------------------
// ple_pkg: shared types for the positional list engine
// Operation and status codes, controller states and the command and
// status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package ple_pkg;

    // operation codes carried on func
    typedef enum logic [2:0] {
        FN_CLEAR  = 3'd0,
        FN_INSERT = 3'd1,
        FN_DELETE = 3'd2,
        FN_READ   = 3'd3,
        FN_LOCATE = 3'd4
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_GET_RD,
        S_GET_WAIT,
        S_FIND_RD,
        S_FIND_CMP,
        S_DONE
    } state_t;

    // scan pointer updates
    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LOAD_CNT,
        PTR_LOAD_IDX,
        PTR_LOAD_ZERO,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    // element count updates
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // memory read address select
    typedef enum logic [1:0] {
        ADDR_PTR,
        ADDR_PTR_DN,
        ADDR_PTR_UP,
        ADDR_IDX
    } addr_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic      load;
        ptr_op_t   ptr_op;
        cnt_op_t   cnt_op;
        logic      rd_en;
        addr_sel_t rd_sel;
        logic      wr_shift;
        logic      wr_val;
        logic      res_init;
        logic      set_status;
        status_t   res_status;
        logic      rd_capture;
        logic      fp_capture;
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] func;
        logic       bad_ins;
        logic       bad_pos;
        logic       full;
        logic       ins_more;
        logic       del_more;
        logic       scan_more;
        logic       match;
    } dp_stat_t;

endpackage

// ===== rtl/core/positional_list_engine_unit.sv =====
// ---------------------------------------------------------------------------
// positional_list_engine_unit: ordered list with insert, delete, read, locate
// Each item is checked first; clear, an unused code or a rejected item then
// goes straight to done. Insert and delete shift entries one at a time, each
// by a read state and a write state; read fetches the entry at the position;
// locate reads and compares entries from the head to a match or the end.
// A new item is taken in the cycle that done is high.
// Reset clears the list length and controller state; no memory clearing pass.
// ---------------------------------------------------------------------------
module positional_list_engine_unit #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic [6:0]         position,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic [6:0]         found_position,
    output logic [6:0]         list_length,
    output logic [1:0]         status
);

    ple_pkg::ctl_cmd_t cmd;
    ple_pkg::dp_stat_t stat;

    // sequencer
    ple_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    // storage and result datapath
    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .func           (func),
        .position       (position),
        .value          (value),
        .read_value     (read_value),
        .found_position (found_position),
        .list_length    (list_length),
        .status         (status)
    );

endmodule

// ===== rtl/core/ple_datapath.sv =====
// ---------------------------------------------------------------------------
// ple_datapath: list storage, pointers and result registers
// Holds the element memory, the element count, the scan pointer and the
// result fields, and reports position checks and compare results.
// ---------------------------------------------------------------------------
module ple_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ple_pkg::ctl_cmd_t   cmd,
    output ple_pkg::dp_stat_t   stat,
    input  logic [2:0]          func,
    input  logic [6:0]          position,
    input  logic signed [31:0]  value,
    output logic signed [31:0]  read_value,
    output logic [6:0]          found_position,
    output logic [6:0]          list_length,
    output logic [1:0]          status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int XW = ((CW > 7) ? CW : 7) + 1;

    logic [31:0]   mem [CAPACITY];
    logic [2:0]    func_reg;
    logic [6:0]    pos_reg;
    logic [31:0]   val_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] ptr_next;
    logic [31:0]   rdata_reg;
    logic [31:0]   rd_reg;
    logic [6:0]    fp_reg;
    logic [1:0]    st_reg;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] ptr_x;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] fp_x;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    // widened views for compares
    assign pos_x = XW'(pos_reg);
    assign cnt_x = XW'(cnt_reg);
    assign ptr_x = XW'(ptr_reg);
    assign idx_x = pos_x - XW'(1);
    assign fp_x  = ptr_x + XW'(1);

    // status toward the controller
    always_comb
    begin
        stat.func      = func_reg;
        stat.bad_ins   = (pos_reg == 7'd0) || (pos_x > cnt_x + XW'(1));
        stat.bad_pos   = (pos_reg == 7'd0) || (pos_x > cnt_x);
        stat.full      = (cnt_reg == CW'(CAPACITY));
        stat.ins_more  = (ptr_x > idx_x);
        stat.del_more  = (ptr_x + XW'(1) < cnt_x);
        stat.scan_more = (ptr_x < cnt_x);
        stat.match     = (rdata_reg == val_reg);
    end

    // item capture on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            pos_reg  <= position;
            val_reg  <= value;
        end
    end

    // pointer next value
    always_comb
    begin
        case (cmd.ptr_op)
            ple_pkg::PTR_LOAD_CNT:  ptr_next = cnt_reg;
            ple_pkg::PTR_LOAD_IDX:  ptr_next = idx_x[CW-1:0];
            ple_pkg::PTR_LOAD_ZERO: ptr_next = '0;
            ple_pkg::PTR_INC:       ptr_next = ptr_reg + CW'(1);
            ple_pkg::PTR_DEC:       ptr_next = ptr_reg - CW'(1);
            default:                ptr_next = ptr_reg;
        endcase
    end

    // count next value
    always_comb
    begin
        case (cmd.cnt_op)
            ple_pkg::CNT_CLR: cnt_next = '0;
            ple_pkg::CNT_INC: cnt_next = cnt_reg + CW'(1);
            ple_pkg::CNT_DEC: cnt_next = cnt_reg - CW'(1);
            default:          cnt_next = cnt_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    // memory address and data select
    always_comb
    begin
        case (cmd.rd_sel)
            ple_pkg::ADDR_PTR_DN: rd_addr = AW'(ptr_reg - CW'(1));
            ple_pkg::ADDR_PTR_UP: rd_addr = AW'(ptr_reg + CW'(1));
            ple_pkg::ADDR_IDX:    rd_addr = idx_x[AW-1:0];
            default:              rd_addr = ptr_reg[AW-1:0];
        endcase
        wr_addr = cmd.wr_val ? idx_x[AW-1:0] : ptr_reg[AW-1:0];
        wr_data = cmd.wr_val ? val_reg : rdata_reg;
    end

    // element memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_shift || cmd.wr_val)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.res_init)
        begin
            rd_reg <= '0;
            fp_reg <= '0;
        end
        else
        begin
            if (cmd.rd_capture)
            begin
                rd_reg <= rdata_reg;
            end
            if (cmd.fp_capture)
            begin
                fp_reg <= fp_x[6:0];
            end
        end
        if (cmd.set_status)
        begin
            st_reg <= cmd.res_status;
        end
    end

    assign read_value     = rd_reg;
    assign found_position = fp_reg;
    assign list_length    = cnt_x[6:0];
    assign status         = st_reg;

endmodule

// ===== rtl/core/ple_ctrl.sv =====
// ---------------------------------------------------------------------------
// ple_ctrl: operation sequencer for the positional list engine
// Checks each item, then steps shifts, reads and scans through the
// element memory and strobes the result.
// ---------------------------------------------------------------------------
module ple_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    input  ple_pkg::dp_stat_t stat,
    output ple_pkg::ctl_cmd_t cmd
);

    ple_pkg::state_t state_reg;
    ple_pkg::state_t state_next;
    logic            accept;

    assign accept = start && !busy;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ple_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = ple_pkg::S_CHECK;
            end
            ple_pkg::S_CHECK:
            begin
                unique case (stat.func)
                    ple_pkg::FN_INSERT:
                        state_next = (stat.bad_ins || stat.full) ? ple_pkg::S_DONE
                                                                 : ple_pkg::S_INS_RD;
                    ple_pkg::FN_DELETE:
                        state_next = stat.bad_pos ? ple_pkg::S_DONE : ple_pkg::S_DEL_RD;
                    ple_pkg::FN_READ:
                        state_next = stat.bad_pos ? ple_pkg::S_DONE : ple_pkg::S_GET_RD;
                    ple_pkg::FN_LOCATE:
                        state_next = ple_pkg::S_FIND_RD;
                    default:
                        state_next = ple_pkg::S_DONE;
                endcase
            end
            ple_pkg::S_INS_RD:
                state_next = stat.ins_more ? ple_pkg::S_INS_WR : ple_pkg::S_DONE;
            ple_pkg::S_INS_WR:
                state_next = ple_pkg::S_INS_RD;
            ple_pkg::S_DEL_RD:
                state_next = stat.del_more ? ple_pkg::S_DEL_WR : ple_pkg::S_DONE;
            ple_pkg::S_DEL_WR:
                state_next = ple_pkg::S_DEL_RD;
            ple_pkg::S_GET_RD:
                state_next = ple_pkg::S_GET_WAIT;
            ple_pkg::S_GET_WAIT:
                state_next = ple_pkg::S_DONE;
            ple_pkg::S_FIND_RD:
                state_next = stat.scan_more ? ple_pkg::S_FIND_CMP : ple_pkg::S_DONE;
            ple_pkg::S_FIND_CMP:
                state_next = stat.match ? ple_pkg::S_DONE : ple_pkg::S_FIND_RD;
            ple_pkg::S_DONE:
                state_next = accept ? ple_pkg::S_CHECK : ple_pkg::S_IDLE;
            default:
                state_next = ple_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        busy = !((state_reg == ple_pkg::S_IDLE) || (state_reg == ple_pkg::S_DONE));
        done = (state_reg == ple_pkg::S_DONE);

        cmd            = '0;
        cmd.ptr_op     = ple_pkg::PTR_HOLD;
        cmd.cnt_op     = ple_pkg::CNT_HOLD;
        cmd.rd_sel     = ple_pkg::ADDR_PTR;
        cmd.res_status = ple_pkg::ST_OK;
        cmd.load       = start && !busy;

        unique case (state_reg)
            ple_pkg::S_CHECK:
            begin
                cmd.res_init   = 1'b1;
                cmd.set_status = 1'b1;
                unique case (stat.func)
                    ple_pkg::FN_CLEAR:
                        cmd.cnt_op = ple_pkg::CNT_CLR;
                    ple_pkg::FN_INSERT:
                    begin
                        cmd.ptr_op = ple_pkg::PTR_LOAD_CNT;
                        if (stat.bad_ins)
                            cmd.res_status = ple_pkg::ST_BADPOS;
                        else if (stat.full)
                            cmd.res_status = ple_pkg::ST_FULL;
                    end
                    ple_pkg::FN_DELETE:
                    begin
                        cmd.ptr_op = ple_pkg::PTR_LOAD_IDX;
                        if (stat.bad_pos)
                            cmd.res_status = ple_pkg::ST_BADPOS;
                    end
                    ple_pkg::FN_READ:
                    begin
                        if (stat.bad_pos)
                            cmd.res_status = ple_pkg::ST_BADPOS;
                    end
                    ple_pkg::FN_LOCATE:
                    begin
                        cmd.ptr_op     = ple_pkg::PTR_LOAD_ZERO;
                        cmd.res_status = ple_pkg::ST_NOTFOUND;
                    end
                    default:
                        cmd.res_status = ple_pkg::ST_OK;
                endcase
            end
            // move entry ptr-1 up, or drop the new value in place
            ple_pkg::S_INS_RD:
            begin
                if (stat.ins_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ple_pkg::ADDR_PTR_DN;
                end
                else
                begin
                    cmd.wr_val = 1'b1;
                    cmd.cnt_op = ple_pkg::CNT_INC;
                end
            end
            ple_pkg::S_INS_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.ptr_op   = ple_pkg::PTR_DEC;
            end
            // move entry ptr+1 down, or shrink the list
            ple_pkg::S_DEL_RD:
            begin
                if (stat.del_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ple_pkg::ADDR_PTR_UP;
                end
                else
                begin
                    cmd.cnt_op = ple_pkg::CNT_DEC;
                end
            end
            ple_pkg::S_DEL_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.ptr_op   = ple_pkg::PTR_INC;
            end
            ple_pkg::S_GET_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ple_pkg::ADDR_IDX;
            end
            ple_pkg::S_GET_WAIT:
                cmd.rd_capture = 1'b1;
            ple_pkg::S_FIND_RD:
            begin
                cmd.rd_en  = stat.scan_more;
                cmd.rd_sel = ple_pkg::ADDR_PTR;
            end
            ple_pkg::S_FIND_CMP:
            begin
                if (stat.match)
                begin
                    cmd.fp_capture = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.res_status = ple_pkg::ST_OK;
                end
                else
                begin
                    cmd.ptr_op = ple_pkg::PTR_INC;
                end
            end
            default:
                cmd.rd_sel = ple_pkg::ADDR_PTR;
        endcase
    end

endmodule

// ===== rtl/core/ple_checker.sv =====
// ---------------------------------------------------------------------------
// ple_checker: port-level checks for the positional list engine
// Watches the command handshake and result strobe over time.
// ---------------------------------------------------------------------------
module ple_checker #(
    parameter int CAPACITY = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] read_value,
    input logic [6:0]  found_position,
    input logic [6:0]  list_length,
    input logic [1:0]  status
);

    localparam logic [6:0] CapLen = 7'(CAPACITY);

    // a transfer always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // a full list reports full length
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ple_pkg::ST_FULL)) |-> (list_length == CapLen))
        else $error("list full reported with wrong length");

    // rejected position returns no data
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ple_pkg::ST_BADPOS)) |->
        ((read_value == 32'd0) && (found_position == 7'd0)))
        else $error("bad position result carries data");

    // a miss reports no position
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ple_pkg::ST_NOTFOUND)) |-> (found_position == 7'd0))
        else $error("not found result carries a position");

endmodule

bind positional_list_engine_unit ple_checker #(
    .CAPACITY (CAPACITY)
) u_ple_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .read_value     (read_value),
    .found_position (found_position),
    .list_length    (list_length),
    .status         (status)
);

// ===== test/positional_list_engine_unit_tb.sv =====
// ---------------------------------------------------------------------------
// positional_list_engine_unit_tb: self-checking bench for the list engine
// Drives clear, insert, delete, read and locate commands, plus the spare
// opcodes. A directed opening is followed by random episodes: list fills up
// to and past capacity, mixed traffic, drains and raw noise. A shadow copy of
// the list predicts every result, and each result is checked in order.
// ---------------------------------------------------------------------------
module positional_list_engine_unit_tb;

    localparam int LIST_CAPACITY  = 64;
    localparam int ITEM_TARGET    = 2000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    // opcodes the block leaves unused
    localparam logic [2:0] FN_SPARE_A = 3'd5;
    localparam logic [2:0] FN_SPARE_B = 3'd6;
    localparam logic [2:0] FN_SPARE_C = 3'd7;

    // one predicted result
    typedef struct {
        logic signed [31:0] read_value;
        logic [6:0]         found_position;
        logic [6:0]         list_length;
        ple_pkg::status_t   status;
    } list_result_t;

    // shadow list and in-order result checker
    class list_tracker #(int DEPTH = 64);
        logic signed [31:0] entries [DEPTH];
        int                 count;
        list_result_t       expected_results [$];
        int                 op_count [8];
        int                 status_count [4];
        int                 transfers;
        int                 results;
        int                 failures;

        function int length();
            return count;
        endfunction

        function logic signed [31:0] entry_at(int idx);
            return entries[idx];
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // apply one command to the shadow list and return its result
        function list_result_t apply_command(logic [2:0] fn, logic [6:0] pos,
                                             logic signed [31:0] val);
            list_result_t r;
            int           p;
            int           k;
            r.read_value     = '0;
            r.found_position = '0;
            r.status         = ple_pkg::ST_OK;
            p = int'(pos);
            case (fn)
                ple_pkg::FN_CLEAR:
                begin
                    count = 0;
                end
                ple_pkg::FN_INSERT:
                begin
                    if (p < 1 || p > count + 1)
                        r.status = ple_pkg::ST_BADPOS;
                    else if (count >= DEPTH)
                        r.status = ple_pkg::ST_FULL;
                    else
                    begin
                        for (k = count; k > p - 1; k--)
                            entries[k] = entries[k - 1];
                        entries[p - 1] = val;
                        count++;
                    end
                end
                ple_pkg::FN_DELETE:
                begin
                    if (p < 1 || p > count)
                        r.status = ple_pkg::ST_BADPOS;
                    else
                    begin
                        for (k = p - 1; k + 1 < count; k++)
                            entries[k] = entries[k + 1];
                        count--;
                    end
                end
                ple_pkg::FN_READ:
                begin
                    if (p < 1 || p > count)
                        r.status = ple_pkg::ST_BADPOS;
                    else
                        r.read_value = entries[p - 1];
                end
                ple_pkg::FN_LOCATE:
                begin
                    r.status = ple_pkg::ST_NOTFOUND;
                    for (k = 0; k < count; k++)
                    begin
                        if (entries[k] === val)
                        begin
                            r.found_position = 7'(k + 1);
                            r.status         = ple_pkg::ST_OK;
                            break;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.list_length = 7'(count);
            return r;
        endfunction

        // accepted command: predict and queue its result
        function void note_command(logic [2:0] fn, logic [6:0] pos,
                                   logic signed [31:0] val);
            list_result_t r;
            r = apply_command(fn, pos, val);
            expected_results.push_back(r);
            transfers++;
            op_count[fn]++;
            status_count[r.status]++;
        endfunction

        // compare one result with the oldest prediction
        function void check_result(logic signed [31:0] rv, logic [6:0] fp,
                                   logic [6:0] len, logic [1:0] st);
            list_result_t e;
            results++;
            if (expected_results.size() == 0)
            begin
                $error("result with no command pending: read_value %0d status %0d",
                       rv, st);
                failures++;
                return;
            end
            e = expected_results.pop_front();
            if (rv !== e.read_value)
            begin
                $error("read_value: expected %0d, got %0d", e.read_value, rv);
                failures++;
            end
            if (fp !== e.found_position)
            begin
                $error("found_position: expected %0d, got %0d", e.found_position, fp);
                failures++;
            end
            if (len !== e.list_length)
            begin
                $error("list_length: expected %0d, got %0d", e.list_length, len);
                failures++;
            end
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                failures++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         func = '0;
    logic [6:0]         position = '0;
    logic signed [31:0] value = '0;
    logic               done;
    logic signed [31:0] read_value;
    logic [6:0]         found_position;
    logic [6:0]         list_length;
    logic [1:0]         status;

    list_tracker #(LIST_CAPACITY) shadow_list;
    int  items_sent = 0;
    int  stall_cycles = 0;
    bit  steady_stream = 1'b0;

    positional_list_engine_unit #(
        .CAPACITY (LIST_CAPACITY)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .position       (position),
        .value          (value),
        .done           (done),
        .read_value     (read_value),
        .found_position (found_position),
        .list_length    (list_length),
        .status         (status)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // idle gap before a command: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_stream || r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // element values: duplicates, extremes and full-range words
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 32'($urandom_range(0, 7));
        else if (r < 34)
            return 32'sh8000_0000;
        else if (r < 38)
            return 32'sh7FFF_FFFF;
        else if (r < 42)
            return -32'sd1;
        else
            return 32'($urandom);
    endfunction

    // locate key: mostly a value held in the list
    function automatic logic signed [31:0] pick_key();
        if (shadow_list.length() > 0 && $urandom_range(0, 99) < 65)
            return shadow_list.entry_at($urandom_range(0, shadow_list.length() - 1));
        return pick_value();
    endfunction

    // insert position: head, tail, or anywhere in between
    function automatic logic [6:0] pick_insert_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 7'd1;
        else if (r < 70)
            return 7'(shadow_list.length() + 1);
        else
            return 7'($urandom_range(1, shadow_list.length() + 1));
    endfunction

    // position inside the list, or a random one when asked or when empty
    function automatic logic [6:0] pick_held_pos(int miss_pct);
        if (shadow_list.length() == 0 || $urandom_range(0, 99) < miss_pct)
            return 7'($urandom_range(0, 127));
        return 7'($urandom_range(1, shadow_list.length()));
    endfunction

    // one command transfer; start stays high after the accepting edge
    task automatic send_item(input logic [2:0] fn, input logic [6:0] pos,
                             input logic signed [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        func     <= fn;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shadow_list.note_command(fn, pos, val);
        items_sent++;
    endtask

    // fill to capacity, then push against the full list
    task automatic fill_list();
        int extra;
        if ($urandom_range(0, 1) == 0)
            send_item(ple_pkg::FN_CLEAR, 7'($urandom), pick_value());
        while (shadow_list.length() < LIST_CAPACITY)
            send_item(ple_pkg::FN_INSERT, pick_insert_pos(), pick_value());
        extra = $urandom_range(1, 4);
        repeat (extra)
            send_item(ple_pkg::FN_INSERT, pick_insert_pos(), pick_value());
        send_item(ple_pkg::FN_INSERT, 7'($urandom_range(LIST_CAPACITY + 2, 127)),
                  pick_value());
        send_item(ple_pkg::FN_LOCATE, 7'($urandom), pick_key());
    endtask

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                shadow_list.check_result(read_value, found_position, list_length, status);
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transfer or result for %0d cycles", stall_cycles);
                $display("positional_list_engine_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int n;
        int r;
        int kind;
        shadow_list = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening: empty list, head and tail builds, edges
        send_item(ple_pkg::FN_READ,   7'd1, 32'sd0);
        send_item(ple_pkg::FN_DELETE, 7'd1, 32'sd0);
        send_item(ple_pkg::FN_LOCATE, 7'd0, 32'sd0);
        send_item(ple_pkg::FN_INSERT, 7'd0, 32'sd9);
        send_item(ple_pkg::FN_INSERT, 7'd2, 32'sd9);
        send_item(ple_pkg::FN_INSERT, 7'd1, 32'sh8000_0000);
        send_item(ple_pkg::FN_INSERT, 7'd2, 32'sh7FFF_FFFF);
        send_item(ple_pkg::FN_INSERT, 7'd1, -32'sd1);
        send_item(ple_pkg::FN_INSERT, 7'd2, 32'sd5);
        send_item(ple_pkg::FN_INSERT, 7'(shadow_list.length() + 1), 32'sd5);
        send_item(ple_pkg::FN_LOCATE, 7'd127, 32'sd5);
        send_item(ple_pkg::FN_LOCATE, 7'd0, 32'sh8000_0000);
        send_item(ple_pkg::FN_LOCATE, 7'd0, 32'sh8000_0005);
        send_item(ple_pkg::FN_READ,   7'd1, 32'sd0);
        send_item(ple_pkg::FN_READ,   7'(shadow_list.length()), 32'sd0);
        send_item(ple_pkg::FN_READ,   7'(shadow_list.length() + 1), 32'sd0);
        send_item(ple_pkg::FN_READ,   7'd127, -32'sd1);
        send_item(ple_pkg::FN_READ,   7'd0, 32'sd0);
        send_item(ple_pkg::FN_DELETE, 7'd127, 32'sd0);
        send_item(ple_pkg::FN_DELETE, 7'd1, 32'sd0);
        send_item(ple_pkg::FN_DELETE, 7'(shadow_list.length()), 32'sd0);
        send_item(FN_SPARE_A, 7'd127, -32'sd1);
        send_item(FN_SPARE_B, 7'd1, 32'sd5);
        send_item(FN_SPARE_C, 7'd0, 32'sd0);
        send_item(ple_pkg::FN_CLEAR,  7'd127, -32'sd1);

        // random episodes, first one always reaches a full list
        kind = 0;
        while (items_sent < ITEM_TARGET)
        begin
            steady_stream = ($urandom_range(0, 3) == 0);
            case (kind)
                0, 1, 2:
                begin
                    fill_list();
                end
                3, 4, 5, 6:
                begin
                    // mixed traffic, mostly in-range positions
                    n = $urandom_range(5, 30);
                    repeat (n)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 30)
                            send_item(ple_pkg::FN_INSERT,
                                      ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                                  : pick_insert_pos(),
                                      pick_value());
                        else if (r < 55)
                            send_item(ple_pkg::FN_DELETE, pick_held_pos(10), pick_value());
                        else if (r < 78)
                            send_item(ple_pkg::FN_READ, pick_held_pos(10), pick_value());
                        else if (r < 98)
                            send_item(ple_pkg::FN_LOCATE, 7'($urandom), pick_key());
                        else
                            send_item(ple_pkg::FN_CLEAR, 7'($urandom), pick_value());
                    end
                end
                7:
                begin
                    // drain to empty, then hit the empty list
                    while (shadow_list.length() > 0)
                        send_item(ple_pkg::FN_DELETE, pick_held_pos(0), pick_value());
                    send_item(ple_pkg::FN_DELETE, 7'd1, pick_value());
                    send_item(ple_pkg::FN_READ, 7'd1, pick_value());
                end
                default:
                begin
                    // raw noise over every field bit
                    n = $urandom_range(3, 15);
                    repeat (n)
                        send_item(3'($urandom), 7'($urandom), 32'($urandom));
                end
            endcase
            kind = $urandom_range(0, 9);
        end
        start <= 1'b0;

        // wait out the remaining results, then watch for strays
        while (shadow_list.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $write("%0d transfers, %0d results: clear %0d, insert %0d, ",
               shadow_list.transfers, shadow_list.results,
               shadow_list.op_count[ple_pkg::FN_CLEAR],
               shadow_list.op_count[ple_pkg::FN_INSERT]);
        $display("delete %0d, read %0d, locate %0d, spare %0d",
                 shadow_list.op_count[ple_pkg::FN_DELETE],
                 shadow_list.op_count[ple_pkg::FN_READ],
                 shadow_list.op_count[ple_pkg::FN_LOCATE],
                 shadow_list.op_count[FN_SPARE_A] + shadow_list.op_count[FN_SPARE_B]
                 + shadow_list.op_count[FN_SPARE_C]);
        $display("outcomes: ok %0d, bad position %0d, list full %0d, not found %0d",
                 shadow_list.status_count[ple_pkg::ST_OK],
                 shadow_list.status_count[ple_pkg::ST_BADPOS],
                 shadow_list.status_count[ple_pkg::ST_FULL],
                 shadow_list.status_count[ple_pkg::ST_NOTFOUND]);
        if (shadow_list.failures == 0)
            $display("positional_list_engine_unit_tb: PASS");
        else
            $display("positional_list_engine_unit_tb: FAIL");
        $finish;
    end

endmodule

// ===== positional_list_engine_unit.f =====
rtl/core/ple_pkg.sv
rtl/core/ple_datapath.sv
rtl/core/ple_ctrl.sv
rtl/core/positional_list_engine_unit.sv
rtl/core/ple_checker.sv
test/positional_list_engine_unit_tb.sv
